// ===== hw/rtl/hmw_pkg.sv =====
package hmw_pkg;

  localparam int PIX_W      = 8;
  localparam int CELL_W     = PIX_W + 1;  // pixel and mask bit
  localparam int SE_INDEX_W = 4;
  localparam int ROWS_W     = 11;
  localparam int COLS_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_LOAD  = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [PIX_W-1:0]      pixel;
    logic                  mask_bit;
    logic [SE_INDEX_W-1:0] se_index;
    logic [PIX_W-1:0]      se_fit;
    logic [PIX_W-1:0]      se_miss;
  } hmw_in_t;

  typedef struct packed {
    logic hit;
    logic last_result;
  } hmw_out_t;

  // match stage control
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } hmw_ctl_t;

endpackage

// ===== hw/rtl/hmw_colstore.sv =====
module hmw_colstore import hmw_pkg::*; #(
  parameter int SLOTS  = 3,
  parameter int DEPTH  = 1024,
  parameter int AW     = 10,
  parameter int SW     = 2
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [AW-1:0]                addr,
  input  logic [SW-1:0]                wr_slot,
  input  logic [CELL_W-1:0]            wr_data,
  output logic [SLOTS-1:0][CELL_W-1:0] rd_data
);

  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_r;

    always_ff @(posedge clk) begin
      if (en && (wr_slot == SW'(i))) begin
        mem[addr] <= wr_data;
      end
      if (en) begin
        rd_r <= mem[addr];
      end
    end

    assign rd_data[i] = rd_r;
  end

endmodule

// ===== hw/rtl/hmw_match.sv =====
module hmw_match import hmw_pkg::*; #(
  parameter int HALF_HEIGHT = 1,
  parameter int HALF_WIDTH  = 1,
  parameter int SW          = 2
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  hmw_ctl_t                                  ctl,
  input  logic                                      advance,
  input  logic [SW-1:0]                             slot,
  input  logic [CELL_W-1:0]                         in_word,
  input  logic [(2*HALF_WIDTH+1)-1:0][CELL_W-1:0]   rd_data,
  input  logic                                      mask_enable,
  input  logic                                      load_en,
  input  logic [SE_INDEX_W-1:0]                     load_index,
  input  logic [PIX_W-1:0]                          load_fit,
  input  logic [PIX_W-1:0]                          load_miss,
  output logic                                      hit
);

  localparam int WIN_H    = 2 * HALF_HEIGHT + 1;
  localparam int WIN_W    = 2 * HALF_WIDTH + 1;
  localparam int WIN_SIZE = WIN_H * WIN_W;
  localparam int TAPS     = (HALF_HEIGHT > 0) ? 2 * HALF_HEIGHT : 1;

  logic [PIX_W-1:0]  fit_r  [WIN_SIZE];
  logic [PIX_W-1:0]  miss_r [WIN_SIZE];
  logic [CELL_W-1:0] tap_r  [TAPS][WIN_W];
  logic [CELL_W-1:0] cur    [WIN_W];
  logic [CELL_W-1:0] wnd    [WIN_H][WIN_W];
  logic              ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < WIN_SIZE; e++) begin
        fit_r[e]  <= '0;
        miss_r[e] <= '0;
      end
    end else if (load_en) begin
      for (int e = 0; e < WIN_SIZE; e++) begin
        if (32'(load_index) == e) begin
          fit_r[e]  <= load_fit;
          miss_r[e] <= load_miss;
        end
      end
    end
  end

  // current column vector in window column order, oldest column first
  always_comb begin
    int sel;
    for (int dc = 0; dc < WIN_W; dc++) begin
      sel = int'(slot) + 1 + dc;
      if (sel >= WIN_W) begin
        sel = sel - WIN_W;
      end
      cur[dc] = in_word;
      for (int j = 0; j < WIN_W; j++) begin
        if (j == sel && sel != int'(slot)) begin
          cur[dc] = rd_data[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid && advance) begin
      tap_r[0] <= cur;
      for (int k = 1; k < TAPS; k++) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  always_comb begin
    for (int dr = 0; dr < WIN_H; dr++) begin
      if (dr == WIN_H - 1) begin
        wnd[dr] = cur;
      end else begin
        wnd[dr] = tap_r[WIN_H-2-dr];
      end
    end
  end

  always_comb begin
    ok = 1'b1;
    for (int dc = 0; dc < WIN_W; dc++) begin
      for (int dr = 0; dr < WIN_H; dr++) begin
        if (fit_r[dc*WIN_H+dr] != wnd[dr][dc][CELL_W-1:1] ||
            miss_r[dc*WIN_H+dr] == wnd[dr][dc][CELL_W-1:1]) begin
          ok = 1'b0;
        end
      end
    end
  end

  assign hit = ok && !(mask_enable && !wnd[HALF_HEIGHT][HALF_WIDTH][0]);

endmodule

// ===== hw/rtl/hit_or_miss_window_match.sv =====
// channel | ports                          | transfer when
// input   | in_valid, in_stall, in_data    | in_valid && !in_stall
// result  | out_valid, out_stall, out_data | out_valid && !out_stall
// config  | cfg_we, cfg_index, cfg_data    | cfg_we
//
// One item per cycle while in_stall is low. A pixel that completes a window
// gives a result through the match stage and column store reads, then the output register.
// Reset clears positions and tables and sets the configuration to defaults;
// column stores hold no reset. in_stall rises only while a result sits in the
// match stage behind a stalled output register.
module hit_or_miss_window_match import hmw_pkg::*; #(
  parameter int HALF_HEIGHT = 1,
  parameter int HALF_WIDTH  = 1,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hmw_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hmw_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WIN_W = 2 * HALF_WIDTH + 1;
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int SW    = (WIN_W > 1) ? $clog2(WIN_W) : 1;
  localparam int RCW   = ($clog2(MAX_ROWS + 1) > ROWS_W) ? $clog2(MAX_ROWS + 1) : ROWS_W;

  logic [ROWS_W-1:0] rows_r;
  logic [COLS_W-1:0] cols_r;
  logic              mask_en_r;

  logic [RW-1:0]     row_r, row_nxt;
  logic [COLS_W-1:0] col_r, col_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;

  hmw_ctl_t          s1_ctl_r, s1_ctl_nxt;
  logic [SW-1:0]     s1_slot_r;
  logic [CELL_W-1:0] s1_cell_r;

  logic              accept, pix_acc, load_acc, s1_go, hit;
  logic [RCW-1:0]    rows_eff, row_ext;
  logic [RCW:0]      row_inc;
  logic [COLS_W:0]   col_inc;
  logic              emit, last;
  logic [WIN_W-1:0][CELL_W-1:0] rd_data;

  assign s1_go    = !(s1_ctl_r.valid && s1_ctl_r.emit && out_valid && out_stall);
  assign in_stall = !s1_go;
  assign accept   = in_valid && !in_stall;
  assign pix_acc  = accept && (in_data.kind == KIND_PIXEL);
  assign load_acc = accept && (in_data.kind == KIND_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= ROWS_W'(1024);
      cols_r    <= COLS_W'(1024);
      mask_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_ROWS:  rows_r    <= cfg_data[ROWS_W-1:0];
        CFG_IMAGE_COLS:  cols_r    <= cfg_data[COLS_W-1:0];
        CFG_MASK_ENABLE: mask_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_eff = (RCW'(rows_r) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_r);
    row_ext  = RCW'(row_r);
    row_inc  = {1'b0, row_ext} + 1'b1;
    col_inc  = {1'b0, col_r} + 1'b1;
    emit = (row_ext >= RCW'(2 * HALF_HEIGHT)) && (col_r >= COLS_W'(2 * HALF_WIDTH)) &&
           (row_ext < rows_eff) && (col_r < cols_r);
    last = (row_inc == {1'b0, rows_eff}) && (col_inc == {1'b0, cols_r});
    row_nxt  = row_r;
    col_nxt  = col_r;
    slot_nxt = slot_r;
    if (pix_acc) begin
      if (row_inc >= {1'b0, rows_eff}) begin
        row_nxt = '0;
        if (col_inc >= {1'b0, cols_r}) begin
          col_nxt  = '0;
          slot_nxt = '0;
        end else begin
          col_nxt  = col_inc[COLS_W-1:0];
          slot_nxt = (slot_r == SW'(WIN_W - 1)) ? '0 : slot_r + 1'b1;
        end
      end else begin
        row_nxt = row_inc[RW-1:0];
      end
    end
  end

  always_comb begin
    s1_ctl_nxt = s1_ctl_r;
    if (pix_acc) begin
      s1_ctl_nxt.valid = 1'b1;
      s1_ctl_nxt.emit  = emit;
      s1_ctl_nxt.last  = last;
    end else if (s1_go) begin
      s1_ctl_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      slot_r    <= '0;
      s1_ctl_r  <= '0;
      out_valid <= 1'b0;
    end else begin
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      slot_r   <= slot_nxt;
      s1_ctl_r <= s1_ctl_nxt;
      if (s1_ctl_r.valid && s1_ctl_r.emit && s1_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_slot_r <= slot_r;
      s1_cell_r <= {in_data.pixel, in_data.mask_bit};
    end
    if (s1_ctl_r.valid && s1_ctl_r.emit && s1_go) begin
      out_data.hit         <= hit;
      out_data.last_result <= s1_ctl_r.last;
    end
  end

  hmw_colstore #(
    .SLOTS (WIN_W),
    .DEPTH (MAX_ROWS),
    .AW    (RW),
    .SW    (SW)
  ) u_store (
    .clk     (clk),
    .en      (pix_acc),
    .addr    (row_r),
    .wr_slot (slot_r),
    .wr_data ({in_data.pixel, in_data.mask_bit}),
    .rd_data (rd_data)
  );

  hmw_match #(
    .HALF_HEIGHT (HALF_HEIGHT),
    .HALF_WIDTH  (HALF_WIDTH),
    .SW          (SW)
  ) u_match (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (s1_ctl_r),
    .advance     (s1_go),
    .slot        (s1_slot_r),
    .in_word     (s1_cell_r),
    .rd_data     (rd_data),
    .mask_enable (mask_en_r),
    .load_en     (load_acc),
    .load_index  (in_data.se_index),
    .load_fit    (in_data.se_fit),
    .load_miss   (in_data.se_miss),
    .hit         (hit)
  );

endmodule

// ===== hw/rtl/hmw_checker.sv =====
module hmw_checker import hmw_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input hmw_in_t               in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input hmw_out_t              out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.kind == KIND_PIXEL, 2))
    else $error("result without pixel transfer");

endmodule

bind hit_or_miss_window_match hmw_checker u_chk (.*);

// ===== tb/hit_or_miss_window_match_test.sv =====
`timescale 1ns / 1ps

module hit_or_miss_window_match_test;
  import hmw_pkg::*;

  localparam int HALF_H     = 1;
  localparam int HALF_W     = 1;
  localparam int ROW_CAP    = 1024;
  localparam int WIN_H      = 2 * HALF_H + 1;
  localparam int WIN_W      = 2 * HALF_W + 1;
  localparam int WIN_CELLS  = WIN_H * WIN_W;
  localparam int DRAIN      = 4;
  localparam int IDLE_LIMIT = 10000;
  localparam int MAX_REPORTS = 10;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  hmw_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  hmw_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  hit_or_miss_window_match #(
    .HALF_HEIGHT(HALF_H),
    .HALF_WIDTH (HALF_W),
    .MAX_ROWS   (ROW_CAP)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // expected behavior: configuration, column stores, element tables, positions
  logic [10:0]  rows_reg    = 11'd1024;
  logic [15:0]  cols_reg    = 16'd1024;
  logic         mask_en_reg = 1'b0;
  logic [7:0]   pix_col [WIN_W][ROW_CAP];
  logic         msk_col [WIN_W][ROW_CAP];
  logic [7:0]   fit_tbl [WIN_CELLS];
  logic [7:0]   miss_tbl [WIN_CELLS];
  int unsigned  row_pos = 0;
  int unsigned  col_pos = 0;
  hmw_out_t     hits_due [$];

  int           src_idle    = 0;
  int           snk_stall   = 0;
  int           mismatches  = 0;
  int           idle_cycles = 0;
  int           items_sent  = 0;
  logic [7:0]   base_px     = 8'h00;

  function automatic void predict_window_hit(input hmw_in_t it);
    int unsigned rows_eff, slot, cslot, top, left, s, e, dc, dr;
    logic [7:0]  v;
    logic        hit;
    hmw_out_t    res;
    rows_eff = (rows_reg > ROW_CAP) ? ROW_CAP : rows_reg;
    if (it.kind == KIND_LOAD) begin
      if (it.se_index < WIN_CELLS) begin
        fit_tbl[it.se_index]  = it.se_fit;
        miss_tbl[it.se_index] = it.se_miss;
      end
      return;
    end
    slot = col_pos % WIN_W;
    pix_col[slot][row_pos] = it.pixel;
    msk_col[slot][row_pos] = it.mask_bit;
    if (row_pos >= 2 * HALF_H && col_pos >= 2 * HALF_W &&
        row_pos < rows_eff && col_pos < cols_reg) begin
      cslot = (col_pos - HALF_W) % WIN_W;
      hit = 1'b1;
      if (mask_en_reg && !msk_col[cslot][row_pos - HALF_H]) begin
        hit = 1'b0;
      end else begin
        top  = row_pos - 2 * HALF_H;
        left = col_pos - 2 * HALF_W;
        for (dc = 0; dc < WIN_W; dc++) begin
          s = (left + dc) % WIN_W;
          for (dr = 0; dr < WIN_H; dr++) begin
            e = dc * WIN_H + dr;
            v = pix_col[s][top + dr];
            if (fit_tbl[e] != v || miss_tbl[e] == v) hit = 1'b0;
          end
        end
      end
      res.hit         = hit;
      res.last_result = (row_pos + 1 == rows_eff) && (col_pos + 1 == cols_reg);
      hits_due.push_back(res);
    end
    if (row_pos + 1 >= rows_eff) begin
      row_pos = 0;
      col_pos = (col_pos + 1 >= cols_reg) ? 0 : col_pos + 1;
    end else begin
      row_pos = row_pos + 1;
    end
  endfunction

  always @(posedge clk) begin
    out_stall <= (snk_stall != 0) && ($urandom_range(99) < snk_stall);
  end

  always @(posedge clk) begin
    hmw_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (hits_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: hit %0b last %0b", out_data.hit, out_data.last_result);
        mismatches++;
      end else begin
        want = hits_due.pop_front();
        if (out_data.hit !== want.hit || out_data.last_result !== want.last_result) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch: hit exp %0b got %0b, last exp %0b got %0b",
                     want.hit, out_data.hit, want.last_result, out_data.last_result);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("hit_or_miss_window_match_test: FAIL");
        $finish;
      end
    end
  end

  task automatic set_pace(input int src, input int snk);
    src_idle  = src;
    snk_stall = snk;
  endtask

  // in_valid stays high between back-to-back transfers
  task automatic send_item(input hmw_in_t it);
    if (src_idle != 0 && $urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_window_hit(it);
    items_sent++;
  endtask

  function automatic hmw_in_t pixel_item(input logic [7:0] px, input logic mb);
    hmw_in_t it;
    it.kind     = KIND_PIXEL;
    it.pixel    = px;
    it.mask_bit = mb;
    it.se_index = 4'($urandom);
    it.se_fit   = 8'($urandom);
    it.se_miss  = 8'($urandom);
    return it;
  endfunction

  task automatic send_load(input logic [3:0] idx, input logic [7:0] fit, input logic [7:0] miss);
    hmw_in_t it;
    it.kind     = KIND_LOAD;
    it.pixel    = 8'($urandom);
    it.mask_bit = 1'($urandom);
    it.se_index = idx;
    it.se_fit   = fit;
    it.se_miss  = miss;
    send_item(it);
  endtask

  task automatic load_uniform(input logic [7:0] fit, input logic [7:0] miss);
    for (int i = 0; i < WIN_CELLS; i++) send_load(4'(i), fit, miss);
  endtask

  function automatic logic [7:0] noisy_px();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 88) return base_px;
    if (r < 94) return 8'($urandom);
    return base_px ^ (8'd1 << $urandom_range(7));
  endfunction

  // sends pixels, with random loads when load_pm is set, until the positions wrap back to the image start
  task automatic send_image(input int load_pm, input bit plain);
    logic mb;
    do begin
      if (load_pm != 0 && $urandom_range(999) < load_pm)
        send_load(4'($urandom), ($urandom_range(3) == 0) ? 8'($urandom) : base_px,
                  8'($urandom));
      mb = ($urandom_range(99) < 80);
      send_item(pixel_item(plain ? 8'($urandom) : noisy_px(), mb));
    end while (row_pos != 0 || col_pos != 0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_IMAGE_ROWS:  rows_reg    = val[10:0];
      CFG_IMAGE_COLS:  cols_reg    = val;
      CFG_MASK_ENABLE: mask_en_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int unsigned rows, input int unsigned cols, input logic mask_on);
    wait_idle();
    cfg_write(CFG_IMAGE_ROWS, {5'($urandom), 11'(rows)});
    cfg_write(CFG_IMAGE_COLS, 16'(cols));
    cfg_write(CFG_MASK_ENABLE, {15'($urandom), mask_on});
  endtask

  task automatic test_element_match();
    set_geometry(3, 3, 1'b0);
    load_uniform(8'hFF, 8'h00);
    repeat (WIN_CELLS) send_item(pixel_item(8'hFF, 1'b1));
    for (int i = 0; i < WIN_CELLS; i++) send_item(pixel_item((i == 5) ? 8'hFE : 8'hFF, 1'b0));
    // loads outside the window are dropped
    send_load(4'd9, 8'h00, 8'hFF);
    send_load(4'd15, 8'h00, 8'hFF);
    repeat (WIN_CELLS) send_item(pixel_item(8'hFF, 1'b1));
    // fit equal to miss never matches
    send_load(4'd4, 8'hFF, 8'hFF);
    repeat (WIN_CELLS) send_item(pixel_item(8'hFF, 1'b1));
    load_uniform(8'h00, 8'hFF);
    repeat (WIN_CELLS) send_item(pixel_item(8'h00, 1'b1));
  endtask

  task automatic test_mask();
    set_geometry(3, 3, 1'b1);
    load_uniform(8'h80, 8'h7F);
    for (int i = 0; i < WIN_CELLS; i++) send_item(pixel_item(8'h80, i != 4));
    for (int i = 0; i < WIN_CELLS; i++) send_item(pixel_item(8'h80, i == 4));
  endtask

  task automatic test_tiny_images();
    int tiny_rows [7] = '{0, 1, 2, 5, 4, 3, 0};
    int tiny_cols [7] = '{4, 3, 5, 2, 1, 0, 0};
    int n;
    base_px = 8'h80;
    for (int k = 0; k < 7; k++) begin
      set_geometry(tiny_rows[k], tiny_cols[k], 1'($urandom));
      n = 0;
      do begin
        send_item(pixel_item(noisy_px(), 1'($urandom)));
        n++;
      end while (n < 4 || row_pos != 0 || col_pos != 0);
    end
  endtask

  task automatic test_midimage_geometry();
    base_px = 8'h3C;
    set_geometry(12, 6, 1'b0);
    load_uniform(8'h3C, 8'hC3);
    send_image(0, 1'b0);
    // shrink rows while inside a column
    repeat (3 * 12 + 7) send_item(pixel_item(noisy_px(), 1'b1));
    set_geometry(5, 6, 1'b0);
    send_image(0, 1'b0);
    // widest column count, then cut it short
    set_geometry(3, 65535, 1'b1);
    repeat (60) send_item(pixel_item(noisy_px(), 1'($urandom)));
    set_geometry(3, 3, 1'b1);
    send_image(0, 1'b0);
  endtask

  task automatic test_row_limit();
    base_px = 8'h5A;
    set_geometry(2047, 3, 1'b0);
    load_uniform(8'h5A, 8'hA5);
    // a column holds ROW_CAP pixels, so this ends three rows into the second column
    repeat (ROW_CAP + 3) send_item(pixel_item(noisy_px(), 1'b1));
    set_geometry(3, 3, 1'b0);
    send_image(0, 1'b0);
  endtask

  task automatic random_image(input bit regeom);
    int unsigned rows, cols, t;
    logic [7:0] miss;
    if (regeom || $urandom_range(99) < 30) begin
      rows = ($urandom_range(9) != 0) ? $urandom_range(10, 3) : $urandom_range(40, 11);
      cols = ($urandom_range(9) != 0) ? $urandom_range(8, 3) : $urandom_range(20, 9);
      set_geometry(rows, cols, 1'($urandom));
    end
    t = $urandom_range(99);
    if (regeom || t < 25) begin
      base_px = 8'($urandom);
      miss = ($urandom_range(19) == 0) ? base_px : 8'($urandom);
      load_uniform(base_px, miss);
    end else if (t < 35) begin
      for (int i = 0; i < WIN_CELLS; i++)
        send_load(4'(i), base_px ^ 8'($urandom_range(3) == 0), 8'($urandom));
    end
    send_image(15, $urandom_range(9) == 0);
  endtask

  task automatic test_random();
    int src_pct [4] = '{0, 45, 0, 21};
    int snk_pct [4] = '{0, 0, 45, 21};
    int start;
    for (int p = 0; p < 4; p++) begin
      set_pace(src_pct[p], snk_pct[p]);
      start = items_sent;
      random_image(1'b1);
      while (items_sent - start < 50) random_image(1'b0);
    end
  endtask

  initial begin
    for (int i = 0; i < WIN_CELLS; i++) begin
      fit_tbl[i]  = 8'h00;
      miss_tbl[i] = 8'h00;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_pace(0, 0);
    test_element_match();
    test_mask();
    test_tiny_images();
    test_midimage_geometry();
    set_pace(21, 21);
    test_row_limit();
    test_random();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && hits_due.size() == 0) begin
      $display("hit_or_miss_window_match_test: PASS");
    end else begin
      $display("hit_or_miss_window_match_test: FAIL");
    end
    $finish;
  end

endmodule
